// ===== design/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, types and state codes for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int COORD_W        = 11;  // center coordinate, signed
  localparam int OUT_W          = 12;  // output coordinate, signed
  localparam int RAD_W          = 7;   // radius and x/y offsets, unsigned
  localparam int DEC_W          = 10;  // decision variable, two's complement
  localparam int STEP_LIMIT     = 64;  // results per circle, hard cap
  localparam int CNT_W          = $clog2(STEP_LIMIT);
  localparam int MAX_RADIUS_DEF = 80;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } mcr_state_t;

  typedef struct packed {
    logic load;   // take a new circle request
    logic step;   // emit one result and advance the decision walk
  } mcr_cmd_t;

  typedef struct packed {
    logic last;   // the step being taken now is the final one
  } mcr_status_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] col_plus_x;
    logic signed [OUT_W-1:0] col_minus_x;
    logic signed [OUT_W-1:0] col_plus_y;
    logic signed [OUT_W-1:0] col_minus_y;
    logic signed [OUT_W-1:0] row_plus_x;
    logic signed [OUT_W-1:0] row_minus_x;
    logic signed [OUT_W-1:0] row_plus_y;
    logic signed [OUT_W-1:0] row_minus_y;
    logic                    last_step;
  } mcr_result_t;

endpackage

// ===== design/mcr_ifs.sv =====
// ----------------------------------------------------------------------------
// mcr_ifs
// Valid/ready channel interfaces for circle requests and octant results.
// ----------------------------------------------------------------------------
interface mcr_req_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mcr_pkg::COORD_W-1:0]   center_col;
  logic signed [mcr_pkg::COORD_W-1:0]   center_row;
  logic        [mcr_pkg::RAD_W-1:0]     radius;

  modport source (output valid, center_col, center_row, radius, input ready);
  modport sink   (input valid, center_col, center_row, radius, output ready);
endinterface

interface mcr_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [mcr_pkg::OUT_W-1:0]   col_plus_x;
  logic signed [mcr_pkg::OUT_W-1:0]   col_minus_x;
  logic signed [mcr_pkg::OUT_W-1:0]   col_plus_y;
  logic signed [mcr_pkg::OUT_W-1:0]   col_minus_y;
  logic signed [mcr_pkg::OUT_W-1:0]   row_plus_x;
  logic signed [mcr_pkg::OUT_W-1:0]   row_minus_x;
  logic signed [mcr_pkg::OUT_W-1:0]   row_plus_y;
  logic signed [mcr_pkg::OUT_W-1:0]   row_minus_y;
  logic                               last_step;

  modport source (output valid, col_plus_x, col_minus_x, col_plus_y, col_minus_y,
                  row_plus_x, row_minus_x, row_plus_y, row_minus_y, last_step,
                  input ready);
  modport sink   (input valid, col_plus_x, col_minus_x, col_plus_y, col_minus_y,
                  row_plus_x, row_minus_x, row_plus_y, row_minus_y, last_step,
                  output ready);
endinterface

// ===== design/midpoint_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Walks the midpoint circle decision variable and emits one beat of eight
// octant-symmetric coordinates per step.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        center_col, center_row, radius
//   out_ch   out  valid/ready        8 coordinates, last_step
//
// A request is loaded into the x/y/decision registers, then the walk takes
// one step per cycle while the output slot is free: about radius/sqrt(2)+1
// steps (57 at radius 80). A new request is taken once the final step has
// been written to the output register, while that beat may still wait.
// Output stalls hold the walk; reset is synchronous and returns to idle.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
  parameter int MAX_RADIUS = mcr_pkg::MAX_RADIUS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mcr_req_if.sink   in_ch,
  mcr_res_if.source out_ch
);
  import mcr_pkg::*;

  mcr_cmd_t    cmd;
  mcr_status_t status;
  mcr_result_t out_item;
  logic        slot_free;

  mcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .slot_free (slot_free),
    .status    (status),
    .cmd       (cmd)
  );

  mcr_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .slot_free  (slot_free),
    .center_col (in_ch.center_col),
    .center_row (in_ch.center_row),
    .radius     (in_ch.radius),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_item   (out_item)
  );

  assign out_ch.col_plus_x  = out_item.col_plus_x;
  assign out_ch.col_minus_x = out_item.col_minus_x;
  assign out_ch.col_plus_y  = out_item.col_plus_y;
  assign out_ch.col_minus_y = out_item.col_minus_y;
  assign out_ch.row_plus_x  = out_item.row_plus_x;
  assign out_ch.row_minus_x = out_item.row_minus_x;
  assign out_ch.row_plus_y  = out_item.row_plus_y;
  assign out_ch.row_minus_y = out_item.row_minus_y;
  assign out_ch.last_step   = out_item.last_step;

  // a request beat always starts a walk
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ch.ready)
    else $error("input ready right after a request beat");

  // the final step frees the input side
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && status.last) |=> in_ch.ready)
    else $error("input not ready after final step");

  // no stepping while idle
  a_step_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ch.ready)
    else $error("step issued while idle");

  // a step always leaves a beat waiting at the output
  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_ch.valid)
    else $error("step did not fill output register");

endmodule

// ===== design/mcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcr_ctrl
// Controller: idles until a request beat, then steps the datapath once per
// free output slot until the final step of the circle.
// ----------------------------------------------------------------------------
module mcr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 slot_free,
  input  mcr_pkg::mcr_status_t status,
  output mcr_pkg::mcr_cmd_t    cmd
);
  import mcr_pkg::*;

  mcr_state_t state_r;
  mcr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (slot_free && status.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step = slot_free;
      end
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

// ===== design/mcr_dp.sv =====
// ----------------------------------------------------------------------------
// mcr_dp
// Datapath: x/y/decision registers, the midpoint update, the eight
// symmetric coordinate adders and the output register.
// ----------------------------------------------------------------------------
module mcr_dp #(
  parameter int MAX_RADIUS = mcr_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mcr_pkg::mcr_cmd_t                   cmd,
  output mcr_pkg::mcr_status_t                status,
  output logic                                slot_free,
  input  logic signed [mcr_pkg::COORD_W-1:0]  center_col,
  input  logic signed [mcr_pkg::COORD_W-1:0]  center_row,
  input  logic        [mcr_pkg::RAD_W-1:0]    radius,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mcr_pkg::mcr_result_t                out_item
);
  import mcr_pkg::*;

  localparam logic [RAD_W-1:0]        RAD_CAP  = RAD_W'(MAX_RADIUS);
  localparam logic signed [DEC_W-1:0] DEC_ONE  = 1;
  localparam logic signed [DEC_W-1:0] INC_NEG  = 3;
  localparam logic signed [DEC_W-1:0] INC_POS  = 5;
  localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(STEP_LIMIT - 1);

  logic        [RAD_W-1:0]   x_r, y_r;
  logic        [RAD_W-1:0]   x_nxt, y_nxt;
  logic signed [DEC_W-1:0]   d_r, d_nxt;
  logic signed [COORD_W-1:0] col_r, row_r;
  logic        [CNT_W-1:0]   cnt_r;
  logic                      out_valid_r;
  mcr_result_t               out_r;
  mcr_result_t               res;

  logic        [RAD_W-1:0]   r_sat;
  logic signed [DEC_W-1:0]   x_d, y_d;
  logic signed [OUT_W-1:0]   col_e, row_e, x_e, y_e;

  assign r_sat = (radius > RAD_CAP) ? RAD_CAP : radius;

  // midpoint update
  assign x_d   = signed'(DEC_W'(x_r));
  assign y_d   = signed'(DEC_W'(y_r));
  assign x_nxt = x_r + RAD_W'(1);

  always_comb begin
    if (d_r[DEC_W-1]) begin
      d_nxt = d_r + x_d + x_d + INC_NEG;
      y_nxt = y_r;
    end else begin
      d_nxt = d_r + (x_d - y_d) + (x_d - y_d) + INC_POS;
      y_nxt = y_r - RAD_W'(1);
    end
  end

  // y at zero ends the walk: y_nxt could wrap below zero
  assign status.last = (x_nxt > y_nxt) || (y_r == '0) || (cnt_r == CNT_LAST);

  // eight-way symmetry
  assign col_e = OUT_W'(col_r);
  assign row_e = OUT_W'(row_r);
  assign x_e   = signed'(OUT_W'(x_r));
  assign y_e   = signed'(OUT_W'(y_r));

  always_comb begin
    res.col_plus_x  = col_e + x_e;
    res.col_minus_x = col_e - x_e;
    res.col_plus_y  = col_e + y_e;
    res.col_minus_y = col_e - y_e;
    res.row_plus_x  = row_e + x_e;
    res.row_minus_x = row_e - x_e;
    res.row_plus_y  = row_e + y_e;
    res.row_minus_y = row_e - y_e;
    res.last_step   = status.last;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= '0;
      y_r   <= r_sat;
      d_r   <= DEC_ONE - signed'(DEC_W'(r_sat));
      col_r <= center_col;
      row_r <= center_row;
      cnt_r <= '0;
    end else if (cmd.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      d_r   <= d_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // output register: refilled on a step, emptied by a beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) out_r <= res;
  end

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== tb/sv/midpoint_circle_rasterizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_tb
// Drives circle requests and checks every octant beat against a predictor
// of the midpoint walk. Directed corners first, then random requests with
// random gaps and stalls on both channels, a long output hold-off and a
// drain pause.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_tb;
  import mcr_pkg::*;

  localparam int RADIUS_CAP  = MAX_RADIUS_DEF;
  localparam int RANDOM_REQS = 153;
  localparam int HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES = 120;

  typedef struct {
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic        [RAD_W-1:0]   rad;
    bit                        no_gap;  // send the next request back to back
    bit                        drain;   // wait for all beats before going on
  } circle_req_t;

  logic clk;
  logic rst_n;

  mcr_req_if req_ch ();
  mcr_res_if res_ch ();

  midpoint_circle_rasterizer #(
    .MAX_RADIUS(RADIUS_CAP)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(res_ch)
  );

  circle_req_t pending_q[$];
  mcr_result_t octant_q[$];
  circle_req_t cur_req;
  int          req_beats;
  int          req_seen;
  bit          offering;
  int          send_gap;
  int          rdy_gap;
  int          rdy_run;
  bit          hold_off;
  int          fails;

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int next_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void walk_circle(input circle_req_t r);
    mcr_result_t beat;
    int cc, cr, x, y, d, n;
    cc = r.col;
    cr = r.row;
    y  = (r.rad > RADIUS_CAP) ? RADIUS_CAP : int'(r.rad);
    x  = 0;
    d  = 1 - y;
    n  = 0;
    while (x <= y && n < STEP_LIMIT) begin
      beat.col_plus_x  = OUT_W'(cc + x);
      beat.col_minus_x = OUT_W'(cc - x);
      beat.col_plus_y  = OUT_W'(cc + y);
      beat.col_minus_y = OUT_W'(cc - y);
      beat.row_plus_x  = OUT_W'(cr + x);
      beat.row_minus_x = OUT_W'(cr - x);
      beat.row_plus_y  = OUT_W'(cr + y);
      beat.row_minus_y = OUT_W'(cr - y);
      if (d < 0) begin
        d += 2 * x + 3;
      end else begin
        d += 2 * (x - y) + 5;
        y--;
      end
      x++;
      n++;
      beat.last_step = (x > y) || (n >= STEP_LIMIT);
      octant_q.push_back(beat);
    end
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  function automatic void add_req(input int col, input int row, input int rad,
                                  input bit no_gap);
    circle_req_t r;
    r.col    = COORD_W'(col);
    r.row    = COORD_W'(row);
    r.rad    = RAD_W'(rad);
    r.no_gap = no_gap;
    r.drain  = 1'b0;
    pending_q.push_back(r);
  endfunction

  function automatic void add_drain();
    circle_req_t r;
    r        = '{default: 0};
    r.drain  = 1'b1;
    pending_q.push_back(r);
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (offering && req_beats != req_seen) begin
        req_seen = req_beats;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].drain) begin
            if (octant_q.size() == 0) void'(pending_q.pop_front());
          end else begin
            cur_req  = pending_q.pop_front();
            offering = 1'b1;
            send_gap = cur_req.no_gap ? 0 : next_gap();
          end
        end
      end
      req_ch.valid      <= offering;
      req_ch.center_col <= cur_req.col;
      req_ch.center_row <= cur_req.row;
      req_ch.radius     <= cur_req.rad;
    end
  end

  // result receiver: random stalls, stall-free runs, and the long hold-off
  always @(negedge clk) begin
    bit rdy_now;
    if (rdy_gap > 0) begin
      rdy_gap--;
      rdy_now = 1'b0;
    end else if (rdy_run > 0) begin
      rdy_run--;
      rdy_now = 1'b1;
    end else begin
      rdy_now = 1'b1;
      if ($urandom_range(0, 19) == 0) rdy_run = $urandom_range(30, 80);
      else if ($urandom_range(0, 3) == 0) rdy_gap = next_gap();
    end
    res_ch.ready <= rdy_now && !hold_off;
  end

  // hold the output off long enough for the input side to back up
  initial begin
    while (req_beats < 40) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor: predict on request beats, check on result beats
  always @(posedge clk) begin
    mcr_result_t want;
    circle_req_t got_req;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        if (octant_q.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          want = octant_q.pop_front();
          check_field("col_plus_x",  want.col_plus_x,  res_ch.col_plus_x);
          check_field("col_minus_x", want.col_minus_x, res_ch.col_minus_x);
          check_field("col_plus_y",  want.col_plus_y,  res_ch.col_plus_y);
          check_field("col_minus_y", want.col_minus_y, res_ch.col_minus_y);
          check_field("row_plus_x",  want.row_plus_x,  res_ch.row_plus_x);
          check_field("row_minus_x", want.row_minus_x, res_ch.row_minus_x);
          check_field("row_plus_y",  want.row_plus_y,  res_ch.row_plus_y);
          check_field("row_minus_y", want.row_minus_y, res_ch.row_minus_y);
          check_field("last_step",   want.last_step,   res_ch.last_step);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        got_req.col    = req_ch.center_col;
        got_req.row    = req_ch.center_row;
        got_req.rad    = req_ch.radius;
        got_req.no_gap = 1'b0;
        got_req.drain  = 1'b0;
        walk_circle(got_req);
        req_beats++;
      end
    end
  end

  initial begin
    int p, col, row, rad;
    clk               = 1'b0;
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.center_col = '0;
    req_ch.center_row = '0;
    req_ch.radius     = '0;
    res_ch.ready      = 1'b0;
    cur_req           = '{default: 0};
    req_beats         = 0;
    req_seen          = 0;
    offering          = 1'b0;
    send_gap          = 0;
    rdy_gap           = 0;
    rdy_run           = 0;
    hold_off          = 1'b0;
    fails             = 0;

    // directed: zero radius, smallest walks, corners, cap and over-cap
    add_req(0, 0, 0, 1'b0);
    add_req(1023, 1023, 0, 1'b1);
    add_req(-1024, -1024, 0, 1'b0);
    add_req(0, 0, 1, 1'b0);
    add_req(0, 0, 2, 1'b1);
    add_req(5, -7, 3, 1'b0);
    add_req(1023, -1024, 80, 1'b0);
    add_req(-1024, 1023, 80, 1'b0);
    add_req(-1, -1, 81, 1'b0);
    add_req(682, -683, 127, 1'b1);
    add_req(-683, 682, 85, 1'b0);
    add_req(100, -100, 10, 1'b0);
    add_req(-500, 300, 47, 1'b0);
    add_req(0, 0, 64, 1'b0);
    add_req(1023, 1023, 79, 1'b0);
    add_req(-1024, -1024, 127, 1'b0);
    add_req(-1, 0, 1, 1'b0);
    add_drain();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == RANDOM_REQS / 2) add_drain();
      p = $urandom_range(0, 99);
      if (p < 80) begin
        col = $signed(COORD_W'($urandom));
        row = $signed(COORD_W'($urandom));
      end else begin
        col = ($urandom_range(0, 1) == 1) ? 1023 : -1024;
        row = ($urandom_range(0, 1) == 1) ? 1023 : -1024;
      end
      p = $urandom_range(0, 99);
      if (p < 50) rad = $urandom_range(0, 8);
      else if (p < 80) rad = $urandom_range(9, 30);
      else if (p < 92) rad = $urandom_range(31, RADIUS_CAP);
      else rad = $urandom_range(RADIUS_CAP + 1, 127);
      add_req(col, row, rad, (i % 40) < 10);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_q.size() > 0 || offering || octant_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("midpoint_circle_rasterizer_tb: PASS");
    end else begin
      $display("midpoint_circle_rasterizer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("midpoint_circle_rasterizer_tb: FAIL");
    $finish;
  end

endmodule
